FILE: design/dspq_pkg.sv
// Shared constants and types for the door sensor pulse qualifier.
package dspq_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam int unsigned CNT_W   = 8;
    localparam int unsigned PHASE_W = 4;
    localparam int unsigned PULSE_W = 6;

    localparam logic [CNT_W-1:0]   CNT_MAX = '1;

    localparam logic [CNT_W-1:0]   RST_RELEASE_LIMIT   = 8'd200;
    localparam logic [CNT_W-1:0]   RST_WINDOW_LENGTH   = 8'd200;
    localparam logic [PHASE_W-1:0] RST_PULSE_DIVIDER   = 4'd2;
    localparam logic [PULSE_W-1:0] RST_PULSE_THRESHOLD = 6'd20;
    localparam logic [PULSE_W-1:0] RST_PULSE_CAP       = 6'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RELEASE_LIMIT   = 3'd0,
        REG_WINDOW_LENGTH   = 3'd1,
        REG_PULSE_DIVIDER   = 3'd2,
        REG_PULSE_THRESHOLD = 3'd3,
        REG_PULSE_CAP       = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_UNKNOWN = 2'd0,
        ST_OPEN    = 2'd1,
        ST_CLOSED  = 2'd2
    } t_status;

endpackage

FILE: design/door_sensor_pulse_qualifier_unit.sv
// Door sensor pulse qualifier: tick-by-tick open/closed detection of a pulsed sensor pin.
//
// Usage:
//   Input channel: one request per scan tick, carrying i_sensor_level and
//   i_clear_forbid, taken at an edge where i_valid is high and o_stall low.
//   Output channel: one result per request (o_sensor_state, o_sleep_allowed,
//   o_wake_enable, o_forbid_flag), taken where o_valid is high and i_stall low.
//   The result of a request is registered and shows on the outputs the cycle
//   after it is accepted. One request per clock while o_stall is low; all counters
//   update combinationally between the tick state registers and the result register.
//   The output register is the only buffer: o_stall rises only while a result
//   is held and the receiver stalls, so a request can be taken in the same
//   cycle the held result leaves. A stalled result stays unchanged.
//   Configuration: i_cfg_we writes i_cfg_data into the register named by
//   i_cfg_idx (release limit, window length, divider, threshold, cap);
//   writes to other indexes are dropped. Write only while the block is idle.
//   Reset (synchronous, i_rst_n low): clear all counters and flags, report
//   the sensor as not yet known, empty the output register, and restore the
//   configuration defaults.
module door_sensor_pulse_qualifier_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_sensor_level,
    input  logic                               i_clear_forbid,
    // output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_sensor_state,
    output logic                               o_sleep_allowed,
    output logic                               o_wake_enable,
    output logic                               o_forbid_flag,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [dspq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dspq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dspq_pkg::*;

    // configuration registers
    logic [CNT_W-1:0]   r_release_limit;
    logic [CNT_W-1:0]   r_window_length;
    logic [PHASE_W-1:0] r_pulse_divider;
    logic [PULSE_W-1:0] r_pulse_threshold;
    logic [PULSE_W-1:0] r_pulse_cap;

    // tick state
    logic [CNT_W-1:0]   r_release_count, n_release_count;
    logic               r_release_done,  n_release_done;
    logic [PHASE_W-1:0] r_phase_count,   n_phase_count;
    logic               r_closed_done,   n_closed_done;
    logic               r_window_active, n_window_active;
    logic [CNT_W-1:0]   r_window_count,  n_window_count;
    logic [PULSE_W-1:0] r_pulse_count,   n_pulse_count;
    t_status            r_status,        n_status;
    logic               r_forbid,        n_forbid;
    logic               r_sleep,         n_sleep;
    logic               n_wake;

    // result register
    logic               r_out_valid;
    t_status            r_out_state;
    logic               r_out_sleep;
    logic               r_out_wake;
    logic               r_out_forbid;

    logic               in_accept;
    logic               out_take;
    logic [CNT_W-1:0]   release_inc;
    logic [CNT_W-1:0]   window_inc;
    logic [PHASE_W:0]   phase_next;

    assign out_take  = r_out_valid & ~i_stall;
    // The result register can load whenever it is empty or being drained.
    assign o_stall   = r_out_valid & i_stall;
    assign in_accept = i_valid & ~o_stall;

    always_comb begin
        n_release_count = r_release_count;
        n_release_done  = r_release_done;
        n_phase_count   = r_phase_count;
        n_closed_done   = r_closed_done;
        n_window_active = r_window_active;
        n_window_count  = r_window_count;
        n_pulse_count   = r_pulse_count;
        n_status        = r_status;
        n_sleep         = r_sleep;
        n_wake          = 1'b0;
        n_forbid        = i_clear_forbid ? 1'b0 : r_forbid;

        release_inc = (r_release_count != CNT_MAX) ? r_release_count + 1'b1 : r_release_count;
        phase_next  = {1'b0, r_phase_count} + 1'b1;

        if (!i_sensor_level) begin
            // Low level: count release ticks until open is declared.
            n_phase_count = '0;
            if (!r_release_done) begin
                n_sleep         = 1'b0;
                n_release_count = release_inc;
                if (release_inc >= r_release_limit) begin
                    n_status       = ST_OPEN;
                    n_release_done = 1'b1;
                    n_forbid       = 1'b1;
                    n_wake         = 1'b1;
                    n_closed_done  = 1'b0;
                end
            end else begin
                n_sleep = 1'b1;
            end
        end else begin
            // High level: run the window and divide ticks into pulses.
            n_release_count = '0;
            if (!r_closed_done) begin
                n_sleep         = 1'b0;
                n_window_active = 1'b1;
                if (phase_next > {1'b0, r_pulse_divider}) begin
                    n_phase_count = '0;
                    if (r_pulse_count < r_pulse_cap) begin
                        n_pulse_count = r_pulse_count + 1'b1;
                    end
                end else begin
                    n_phase_count = phase_next[PHASE_W-1:0];
                end
            end else begin
                n_sleep = 1'b1;
            end
        end

        window_inc = (r_window_count != CNT_MAX) ? r_window_count + 1'b1 : r_window_count;

        if (n_window_active) begin
            n_window_count = window_inc;
            if (window_inc >= r_window_length) begin
                // Window end: qualify the pulse count.
                n_window_count  = '0;
                n_window_active = 1'b0;
                if (n_pulse_count >= r_pulse_threshold) begin
                    n_pulse_count = '0;
                    if (!n_forbid) begin
                        n_status       = ST_CLOSED;
                        n_closed_done  = 1'b1;
                        n_release_done = 1'b0;
                    end
                end
            end
        end else begin
            n_window_count = '0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_limit   <= RST_RELEASE_LIMIT;
            r_window_length   <= RST_WINDOW_LENGTH;
            r_pulse_divider   <= RST_PULSE_DIVIDER;
            r_pulse_threshold <= RST_PULSE_THRESHOLD;
            r_pulse_cap       <= RST_PULSE_CAP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RELEASE_LIMIT:   r_release_limit   <= i_cfg_data;
                REG_WINDOW_LENGTH:   r_window_length   <= i_cfg_data;
                REG_PULSE_DIVIDER:   r_pulse_divider   <= i_cfg_data[PHASE_W-1:0];
                REG_PULSE_THRESHOLD: r_pulse_threshold <= i_cfg_data[PULSE_W-1:0];
                REG_PULSE_CAP:       r_pulse_cap       <= i_cfg_data[PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // tick state: advance only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_count <= '0;
            r_release_done  <= 1'b0;
            r_phase_count   <= '0;
            r_closed_done   <= 1'b0;
            r_window_active <= 1'b0;
            r_window_count  <= '0;
            r_pulse_count   <= '0;
            r_status        <= ST_UNKNOWN;
            r_forbid        <= 1'b0;
            r_sleep         <= 1'b0;
        end else if (in_accept) begin
            r_release_count <= n_release_count;
            r_release_done  <= n_release_done;
            r_phase_count   <= n_phase_count;
            r_closed_done   <= n_closed_done;
            r_window_active <= n_window_active;
            r_window_count  <= n_window_count;
            r_pulse_count   <= n_pulse_count;
            r_status        <= n_status;
            r_forbid        <= n_forbid;
            r_sleep         <= n_sleep;
        end
    end

    // result register: valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register: payload, hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_state  <= n_status;
            r_out_sleep  <= n_sleep;
            r_out_wake   <= n_wake;
            r_out_forbid <= n_forbid;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sensor_state  = r_out_state;
    assign o_sleep_allowed = r_out_sleep;
    assign o_wake_enable   = r_out_wake;
    assign o_forbid_flag   = r_out_forbid;

endmodule
